FILE: design/pose_align_p_controller_macros.svh
// Assertion macros used by pap_ctrl of the pose alignment controller.
`ifndef POSE_ALIGN_P_CONTROLLER_MACROS_SVH
`define POSE_ALIGN_P_CONTROLLER_MACROS_SVH

// Checks that the consequent holds on the cycle after the antecedent.
`define PAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define PAP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/pap_pkg.sv
package pap_pkg;

    localparam int POS_W        = 16;
    localparam int ANG_W        = 16;
    localparam int CNT_W        = 16;
    localparam int CORDIC_STEPS = 14;
    localparam int ITER_W       = 4;
    localparam int PROD_W       = 38;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_MEAS  = 2'd1;
    localparam logic [1:0] ACT_FAIL  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_ADJ     = 3'd1;
    localparam logic [2:0] ST_DWELL   = 3'd2;
    localparam logic [2:0] ST_SUCCESS = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;

    localparam logic [2:0] REG_XY_TOL  = 3'd0;
    localparam logic [2:0] REG_YAW_TOL = 3'd1;
    localparam logic [2:0] REG_GAIN_L  = 3'd2;
    localparam logic [2:0] REG_GAIN_A  = 3'd3;
    localparam logic [2:0] REG_TIMEOUT = 3'd4;
    localparam logic [2:0] REG_DWELL   = 3'd5;

    localparam logic [14:0] RST_XY_TOL  = 15'd102;
    localparam logic [14:0] RST_YAW_TOL = 15'd1043;
    localparam logic [11:0] RST_GAIN_L  = 12'd512;
    localparam logic [11:0] RST_GAIN_A  = 12'd768;
    localparam logic [15:0] RST_TIMEOUT = 16'd90;
    localparam logic [15:0] RST_DWELL   = 16'd15;

    localparam logic signed [17:0] CORDIC_K = 18'sd19898;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ADJ,
        MODE_DWELL
    } t_mode;

    typedef enum logic [4:0] {
        S_IDLE, S_UPD, S_DIFF, S_SQ_X, S_SQ_Y, S_SQ_TOL, S_DECIDE,
        S_G_X, S_G_Y, S_G_H, S_G_END, S_C_INIT, S_C_ITER,
        S_K_X, S_K_Y, S_K_END, S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_UPDATE, OP_DIFF, OP_SQ_X, OP_SQ_Y, OP_SQ_TOL,
        OP_DECIDE, OP_G_X, OP_G_Y, OP_G_H, OP_G_END, OP_C_INIT, OP_C_ITER,
        OP_K_X, OP_K_Y, OP_K_END, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic trivial;
        logic compute;
        logic last_iter;
        logic out_free;
    } t_dp_st;

    typedef struct packed {
        logic [14:0] xy_tol;
        logic [14:0] yaw_tol;
        logic [11:0] gain_lin;
        logic [11:0] gain_ang;
        logic [15:0] timeout_ticks;
        logic [15:0] dwell_ticks;
    } t_cfg;

    function automatic logic [13:0] atan_turn(input logic [ITER_W-1:0] idx);
        logic [13:0] v;
        unique case (idx)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PROD_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 38'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -38'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

endpackage

FILE: design/pap_ctrl.sv
`include "pose_align_p_controller_macros.svh"

module pap_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  pap_pkg::t_dp_st i_st,
    output logic            o_s_tready,
    output pap_pkg::t_cmd   o_cmd
);

    pap_pkg::t_state r_state;
    pap_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pap_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd.op   = pap_pkg::OP_NONE;
        unique case (r_state)
            pap_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = pap_pkg::OP_CAPTURE;
                    n_state  = pap_pkg::S_UPD;
                end
            end
            pap_pkg::S_UPD: begin
                o_cmd.op = pap_pkg::OP_UPDATE;
                n_state  = i_st.trivial ? pap_pkg::S_EMIT : pap_pkg::S_DIFF;
            end
            pap_pkg::S_DIFF: begin
                o_cmd.op = pap_pkg::OP_DIFF;
                n_state  = pap_pkg::S_SQ_X;
            end
            pap_pkg::S_SQ_X: begin
                o_cmd.op = pap_pkg::OP_SQ_X;
                n_state  = pap_pkg::S_SQ_Y;
            end
            pap_pkg::S_SQ_Y: begin
                o_cmd.op = pap_pkg::OP_SQ_Y;
                n_state  = pap_pkg::S_SQ_TOL;
            end
            pap_pkg::S_SQ_TOL: begin
                o_cmd.op = pap_pkg::OP_SQ_TOL;
                n_state  = pap_pkg::S_DECIDE;
            end
            pap_pkg::S_DECIDE: begin
                o_cmd.op = pap_pkg::OP_DECIDE;
                n_state  = i_st.compute ? pap_pkg::S_G_X : pap_pkg::S_EMIT;
            end
            pap_pkg::S_G_X: begin
                o_cmd.op = pap_pkg::OP_G_X;
                n_state  = pap_pkg::S_G_Y;
            end
            pap_pkg::S_G_Y: begin
                o_cmd.op = pap_pkg::OP_G_Y;
                n_state  = pap_pkg::S_G_H;
            end
            pap_pkg::S_G_H: begin
                o_cmd.op = pap_pkg::OP_G_H;
                n_state  = pap_pkg::S_G_END;
            end
            pap_pkg::S_G_END: begin
                o_cmd.op = pap_pkg::OP_G_END;
                n_state  = pap_pkg::S_C_INIT;
            end
            pap_pkg::S_C_INIT: begin
                o_cmd.op = pap_pkg::OP_C_INIT;
                n_state  = pap_pkg::S_C_ITER;
            end
            pap_pkg::S_C_ITER: begin
                o_cmd.op = pap_pkg::OP_C_ITER;
                if (i_st.last_iter) begin
                    n_state = pap_pkg::S_K_X;
                end
            end
            pap_pkg::S_K_X: begin
                o_cmd.op = pap_pkg::OP_K_X;
                n_state  = pap_pkg::S_K_Y;
            end
            pap_pkg::S_K_Y: begin
                o_cmd.op = pap_pkg::OP_K_Y;
                n_state  = pap_pkg::S_K_END;
            end
            pap_pkg::S_K_END: begin
                o_cmd.op = pap_pkg::OP_K_END;
                n_state  = pap_pkg::S_EMIT;
            end
            pap_pkg::S_EMIT: begin
                o_cmd.op = pap_pkg::OP_EMIT;
                if (i_st.out_free) begin
                    n_state = pap_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pap_pkg::S_IDLE;
            end
        endcase
    end

    `PAP_ASSERT_NEXT(a_capture, (r_state == pap_pkg::S_IDLE) && i_s_tvalid, r_state == pap_pkg::S_UPD, "accepted word did not start an update")
    `PAP_ASSERT_NEXT(a_emit, (r_state == pap_pkg::S_EMIT) && i_st.out_free, r_state == pap_pkg::S_IDLE, "result not released")
    `PAP_ASSERT_NEXT(a_trivial, (r_state == pap_pkg::S_UPD) && i_st.trivial, r_state == pap_pkg::S_EMIT, "trivial word ran the datapath")
    `PAP_ASSERT_NOW(a_rotate, r_state == pap_pkg::S_K_X, $past(r_state) == pap_pkg::S_C_ITER, "scaling entered without rotation")

endmodule

FILE: design/pap_dp.sv
module pap_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pap_pkg::t_cmd  i_cmd,
    input  pap_pkg::t_cfg  i_cfg,
    input  logic [1:0]     i_s_tuser,
    input  logic [47:0]    i_s_tdata,
    input  logic           i_m_tready,
    output pap_pkg::t_dp_st o_st,
    output logic           o_m_tvalid,
    output logic [47:0]    o_m_tdata,
    output logic [3:0]     o_m_tuser
);

    logic [1:0]         r_act;
    logic [15:0]        r_px, r_py, r_ph;
    logic [15:0]        r_goal_x, r_goal_y, r_goal_h;
    logic [15:0]        r_last_x, r_last_y, r_last_h;
    logic [15:0]        r_elapsed, r_dwell;
    pap_pkg::t_mode     r_mode;
    logic signed [16:0] r_dx, r_dy;
    logic signed [15:0] r_dh;
    logic signed [37:0] r_prod;
    logic [34:0]        r_acc;
    logic signed [19:0] r_cx, r_cy;
    logic signed [17:0] r_z;
    logic [3:0]         r_iter;
    logic signed [15:0] r_vx, r_vy, r_vyaw;
    logic               r_valid;
    logic [2:0]         r_status;
    logic               r_m_valid;
    logic [47:0]        r_m_data;
    logic [3:0]         r_m_user;

    logic signed [19:0] w_mul_a;
    logic signed [17:0] w_mul_b;
    logic signed [37:0] w_mul;
    logic [16:0]        w_abs_dx, w_abs_dy;
    logic [15:0]        w_abs_dh;
    logic               w_ok, w_tmo, w_fail_adj, w_compute, w_out_free;
    logic [15:0]        w_dc;
    logic signed [15:0] w_z0;
    logic signed [19:0] w_sx, w_sy;
    logic signed [17:0] w_atan;

    assign w_abs_dx   = r_dx[16] ? 17'(-r_dx) : 17'(r_dx);
    assign w_abs_dy   = r_dy[16] ? 17'(-r_dy) : 17'(r_dy);
    assign w_abs_dh   = r_dh[15] ? 16'(-r_dh) : 16'(r_dh);
    assign w_ok       = (r_acc <= 35'(r_prod[29:0])) && (w_abs_dh <= 16'(i_cfg.yaw_tol));
    assign w_tmo      = r_elapsed >= i_cfg.timeout_ticks;
    assign w_fail_adj = (r_act == pap_pkg::ACT_FAIL) && (r_mode == pap_pkg::MODE_ADJ);
    assign w_compute  = !w_fail_adj && !w_ok && !w_tmo;
    assign w_dc       = pap_pkg::cnt_inc((r_mode == pap_pkg::MODE_ADJ) ? 16'd0 : r_dwell);
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_z0       = 16'(16'd0 - r_last_h);
    assign w_sx       = r_cx >>> r_iter;
    assign w_sy       = r_cy >>> r_iter;
    assign w_atan     = 18'($signed({1'b0, pap_pkg::atan_turn(r_iter)}));

    assign o_st.trivial   = (r_act == pap_pkg::ACT_START) || (r_act == pap_pkg::ACT_NONE)
                            || (r_mode == pap_pkg::MODE_IDLE);
    assign o_st.compute   = w_compute;
    assign o_st.last_iter = r_iter == 4'(pap_pkg::CORDIC_STEPS - 1);
    assign o_st.out_free  = w_out_free;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.op)
            pap_pkg::OP_SQ_X: begin
                w_mul_a = 20'(r_dx);
                w_mul_b = 18'(r_dx);
            end
            pap_pkg::OP_SQ_Y: begin
                w_mul_a = 20'(r_dy);
                w_mul_b = 18'(r_dy);
            end
            pap_pkg::OP_SQ_TOL: begin
                w_mul_a = 20'($signed({5'd0, i_cfg.xy_tol}));
                w_mul_b = 18'($signed({3'd0, i_cfg.xy_tol}));
            end
            pap_pkg::OP_G_X: begin
                w_mul_a = 20'(r_dx);
                w_mul_b = 18'($signed({6'd0, i_cfg.gain_lin}));
            end
            pap_pkg::OP_G_Y: begin
                w_mul_a = 20'(r_dy);
                w_mul_b = 18'($signed({6'd0, i_cfg.gain_lin}));
            end
            pap_pkg::OP_G_H: begin
                w_mul_a = 20'(r_dh);
                w_mul_b = 18'($signed({6'd0, i_cfg.gain_ang}));
            end
            pap_pkg::OP_K_X: begin
                w_mul_a = r_cx;
                w_mul_b = pap_pkg::CORDIC_K;
            end
            pap_pkg::OP_K_Y: begin
                w_mul_a = r_cy;
                w_mul_b = pap_pkg::CORDIC_K;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul = 38'(w_mul_a) * 38'(w_mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x  <= '0;
            r_goal_y  <= '0;
            r_goal_h  <= '0;
            r_last_x  <= '0;
            r_last_y  <= '0;
            r_last_h  <= '0;
            r_elapsed <= '0;
            r_dwell   <= '0;
            r_mode    <= pap_pkg::MODE_IDLE;
            r_iter    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if ((i_cmd.op == pap_pkg::OP_EMIT) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                pap_pkg::OP_UPDATE: begin
                    if (r_act == pap_pkg::ACT_START) begin
                        r_goal_x  <= r_px;
                        r_goal_y  <= r_py;
                        r_goal_h  <= r_ph;
                        r_elapsed <= '0;
                        r_dwell   <= '0;
                        r_mode    <= pap_pkg::MODE_ADJ;
                    end else if (r_act != pap_pkg::ACT_NONE && r_mode != pap_pkg::MODE_IDLE) begin
                        if (r_act == pap_pkg::ACT_MEAS) begin
                            r_last_x <= r_px;
                            r_last_y <= r_py;
                            r_last_h <= r_ph;
                        end
                        r_elapsed <= pap_pkg::cnt_inc(r_elapsed);
                    end
                end
                pap_pkg::OP_DECIDE: begin
                    if (w_fail_adj) begin
                        if (!w_ok && w_tmo) begin
                            r_mode <= pap_pkg::MODE_IDLE;
                        end
                    end else if (w_ok) begin
                        r_dwell <= w_dc;
                        r_mode  <= (w_dc >= i_cfg.dwell_ticks) ? pap_pkg::MODE_IDLE
                                                               : pap_pkg::MODE_DWELL;
                    end else if (w_tmo) begin
                        r_mode <= pap_pkg::MODE_IDLE;
                    end else begin
                        r_mode  <= pap_pkg::MODE_ADJ;
                        r_dwell <= '0;
                    end
                end
                pap_pkg::OP_C_INIT: begin
                    r_iter <= '0;
                end
                pap_pkg::OP_C_ITER: begin
                    r_iter <= r_iter + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            pap_pkg::OP_CAPTURE: begin
                r_act <= i_s_tuser;
                r_px  <= i_s_tdata[15:0];
                r_py  <= i_s_tdata[31:16];
                r_ph  <= i_s_tdata[47:32];
            end
            pap_pkg::OP_UPDATE: begin
                r_vx     <= '0;
                r_vy     <= '0;
                r_vyaw   <= '0;
                r_valid  <= 1'b0;
                r_status <= (r_act == pap_pkg::ACT_START) ? pap_pkg::ST_ADJ
                                                          : 3'({1'b0, r_mode});
            end
            pap_pkg::OP_DIFF: begin
                r_dx <= 17'($signed(r_goal_x)) - 17'($signed(r_last_x));
                r_dy <= 17'($signed(r_goal_y)) - 17'($signed(r_last_y));
                r_dh <= $signed(r_goal_h - r_last_h);
            end
            pap_pkg::OP_SQ_X: begin
                r_prod <= w_mul;
            end
            pap_pkg::OP_SQ_Y: begin
                r_acc  <= 35'(r_prod[32:0]);
                r_prod <= w_mul;
            end
            pap_pkg::OP_SQ_TOL: begin
                r_acc  <= r_acc + 35'(r_prod[32:0]);
                r_prod <= w_mul;
            end
            pap_pkg::OP_DECIDE: begin
                if (w_fail_adj) begin
                    if (!w_ok && w_tmo) begin
                        r_valid  <= 1'b1;
                        r_status <= pap_pkg::ST_TIMEOUT;
                    end else begin
                        r_status <= pap_pkg::ST_ADJ;
                    end
                end else if (w_ok) begin
                    r_valid  <= 1'b1;
                    r_status <= (w_dc >= i_cfg.dwell_ticks) ? pap_pkg::ST_SUCCESS
                                                            : pap_pkg::ST_DWELL;
                end else if (w_tmo) begin
                    r_valid  <= 1'b1;
                    r_status <= pap_pkg::ST_TIMEOUT;
                end else begin
                    r_valid  <= 1'b1;
                    r_status <= pap_pkg::ST_ADJ;
                end
            end
            pap_pkg::OP_G_X: begin
                r_prod <= w_mul;
            end
            pap_pkg::OP_G_Y: begin
                r_vx   <= (w_abs_dx > 17'(i_cfg.xy_tol)) ? pap_pkg::sat_pos(r_prod >>> 8) : '0;
                r_prod <= w_mul;
            end
            pap_pkg::OP_G_H: begin
                r_vy   <= (w_abs_dy > 17'(i_cfg.xy_tol)) ? pap_pkg::sat_pos(r_prod >>> 8) : '0;
                r_prod <= w_mul;
            end
            pap_pkg::OP_G_END: begin
                r_vyaw <= (w_abs_dh > 16'(i_cfg.yaw_tol)) ? pap_pkg::sat_pos(r_prod >>> 8) : '0;
            end
            pap_pkg::OP_C_INIT: begin
                if (w_z0 > 16'sd16384 || w_z0 < -16'sd16384) begin
                    r_cx <= -20'(r_vx);
                    r_cy <= -20'(r_vy);
                    r_z  <= (w_z0 > 16'sd0) ? 18'(w_z0) - 18'sd32768 : 18'(w_z0) + 18'sd32768;
                end else begin
                    r_cx <= 20'(r_vx);
                    r_cy <= 20'(r_vy);
                    r_z  <= 18'(w_z0);
                end
            end
            pap_pkg::OP_C_ITER: begin
                if (r_z >= 18'sd0) begin
                    r_cx <= r_cx - w_sy;
                    r_cy <= r_cy + w_sx;
                    r_z  <= r_z - w_atan;
                end else begin
                    r_cx <= r_cx + w_sy;
                    r_cy <= r_cy - w_sx;
                    r_z  <= r_z + w_atan;
                end
            end
            pap_pkg::OP_K_X: begin
                r_prod <= w_mul;
            end
            pap_pkg::OP_K_Y: begin
                r_vx   <= pap_pkg::sat_pos(r_prod >>> 15);
                r_prod <= w_mul;
            end
            pap_pkg::OP_K_END: begin
                r_vy <= pap_pkg::sat_pos(r_prod >>> 15);
            end
            pap_pkg::OP_EMIT: begin
                if (w_out_free) begin
                    r_m_data <= {r_vyaw, r_vy, r_vx};
                    r_m_user <= {r_status, r_valid};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule

FILE: design/pose_align_p_controller.sv
// A start, an ignored tick or an idle tick skips the datapath; a tick that needs no
// command ends after the tolerance decision; a tick that issues a proportional
// command also runs the gain products, the 14 steps of the CORDIC unit and the
// scaling, with the sequenced use of one multiplier. One word is processed at a time.
// Reset (synchronous, active low) restores register defaults and an idle controller.
module pose_align_p_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x, pos_y, heading
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // vel_x, vel_y, vel_yaw
    output logic [3:0]  m_tuser,   // cmd_valid, status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pap_pkg::t_cfg   r_cfg;
    pap_pkg::t_cmd   w_cmd;
    pap_pkg::t_dp_st w_st;
    logic            w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.xy_tol        <= pap_pkg::RST_XY_TOL;
            r_cfg.yaw_tol       <= pap_pkg::RST_YAW_TOL;
            r_cfg.gain_lin      <= pap_pkg::RST_GAIN_L;
            r_cfg.gain_ang      <= pap_pkg::RST_GAIN_A;
            r_cfg.timeout_ticks <= pap_pkg::RST_TIMEOUT;
            r_cfg.dwell_ticks   <= pap_pkg::RST_DWELL;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                pap_pkg::REG_XY_TOL:  r_cfg.xy_tol        <= pwdata[14:0];
                pap_pkg::REG_YAW_TOL: r_cfg.yaw_tol       <= pwdata[14:0];
                pap_pkg::REG_GAIN_L:  r_cfg.gain_lin      <= pwdata[11:0];
                pap_pkg::REG_GAIN_A:  r_cfg.gain_ang      <= pwdata[11:0];
                pap_pkg::REG_TIMEOUT: r_cfg.timeout_ticks <= pwdata[15:0];
                pap_pkg::REG_DWELL:   r_cfg.dwell_ticks   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            pap_pkg::REG_XY_TOL:  prdata = 32'(r_cfg.xy_tol);
            pap_pkg::REG_YAW_TOL: prdata = 32'(r_cfg.yaw_tol);
            pap_pkg::REG_GAIN_L:  prdata = 32'(r_cfg.gain_lin);
            pap_pkg::REG_GAIN_A:  prdata = 32'(r_cfg.gain_ang);
            pap_pkg::REG_TIMEOUT: prdata = 32'(r_cfg.timeout_ticks);
            pap_pkg::REG_DWELL:   prdata = 32'(r_cfg.dwell_ticks);
            default:              prdata = '0;
        endcase
    end

    pap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_st       (w_st),
        .o_s_tready (s_tready),
        .o_cmd      (w_cmd)
    );

    pap_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cfg      (r_cfg),
        .i_s_tuser  (s_tuser),
        .i_s_tdata  (s_tdata),
        .i_m_tready (m_tready),
        .o_st       (w_st),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

endmodule

FILE: bench/pose_align_p_controller_chk.sv
module pose_align_p_controller_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [3:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] vyaw;
        logic        cmd;
        logic [2:0]  status;
    } t_cmd_word;

    t_cmd_word      cmd_queue[$];
    pap_pkg::t_cfg  cfg;
    logic [15:0]    gx, gy, gh, lx, ly, lh, elapsed, dwell;
    pap_pkg::t_mode mode;
    int             fails;
    int             results;

    localparam int ATANS[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10,
                                 5, 3, 1};

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp16(longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic bit within_tol();
        longint dx, dy, dh;
        dx = longint'($signed(gx)) - longint'($signed(lx));
        dy = longint'($signed(gy)) - longint'($signed(ly));
        dh = longint'($signed(16'(gh - lh)));
        if (dh < 0) dh = -dh;
        return (dx * dx + dy * dy) <= longint'(cfg.xy_tol) * longint'(cfg.xy_tol) &&
               dh <= longint'(cfg.yaw_tol);
    endfunction

    task automatic rotate_by_heading(inout longint x, inout longint y, input logic [15:0] h);
        longint z, sx, sy;
        z = longint'($signed(16'(16'd0 - h)));
        if (z > 16384 || z < -16384) begin
            x = -x;
            y = -y;
            z = (z > 0) ? z - 32768 : z + 32768;
        end
        for (int i = 0; i < 14; i++) begin
            sx = floor_shr(x, i);
            sy = floor_shr(y, i);
            if (z >= 0) begin
                x -= sy; y += sx; z -= ATANS[i];
            end else begin
                x += sy; y -= sx; z += ATANS[i];
            end
        end
        x = clamp16(floor_shr(x * 19898, 15));
        y = clamp16(floor_shr(y * 19898, 15));
    endtask

    task automatic predict_command(input logic [1:0] act, input logic [47:0] d);
        longint vx, vy, vyaw, dx, dy, dh;
        t_cmd_word w;
        bit ok;
        vx = 0; vy = 0; vyaw = 0;
        w = '0;
        w.status = {1'b0, mode};
        if (act == pap_pkg::ACT_START) begin
            gx = d[15:0]; gy = d[31:16]; gh = d[47:32];
            elapsed = 0; dwell = 0; mode = pap_pkg::MODE_ADJ; w.status = pap_pkg::ST_ADJ;
        end else if (act != pap_pkg::ACT_NONE && mode != pap_pkg::MODE_IDLE) begin
            if (act == pap_pkg::ACT_MEAS) begin
                lx = d[15:0]; ly = d[31:16]; lh = d[47:32];
            end
            if (elapsed != 16'hffff) elapsed++;
            ok = within_tol();
            if (act == pap_pkg::ACT_FAIL && mode == pap_pkg::MODE_ADJ) begin
                if (!ok && elapsed >= cfg.timeout_ticks) begin
                    w.cmd = 1; w.status = pap_pkg::ST_TIMEOUT; mode = pap_pkg::MODE_IDLE;
                end else begin
                    w.status = pap_pkg::ST_ADJ;
                end
            end else if (ok) begin
                if (mode == pap_pkg::MODE_ADJ) begin
                    mode = pap_pkg::MODE_DWELL; dwell = 0;
                end
                if (dwell != 16'hffff) dwell++;
                w.cmd = 1;
                if (dwell >= cfg.dwell_ticks) begin
                    w.status = pap_pkg::ST_SUCCESS; mode = pap_pkg::MODE_IDLE;
                end else begin
                    w.status = pap_pkg::ST_DWELL;
                end
            end else if (elapsed >= cfg.timeout_ticks) begin
                w.cmd = 1; w.status = pap_pkg::ST_TIMEOUT; mode = pap_pkg::MODE_IDLE;
            end else begin
                dx = longint'($signed(gx)) - longint'($signed(lx));
                dy = longint'($signed(gy)) - longint'($signed(ly));
                dh = longint'($signed(16'(gh - lh)));
                mode = pap_pkg::MODE_ADJ; dwell = 0;
                if ((dx < 0 ? -dx : dx) > cfg.xy_tol)
                    vx = clamp16(floor_shr(dx * longint'(cfg.gain_lin), 8));
                if ((dy < 0 ? -dy : dy) > cfg.xy_tol)
                    vy = clamp16(floor_shr(dy * longint'(cfg.gain_lin), 8));
                if ((dh < 0 ? -dh : dh) > cfg.yaw_tol)
                    vyaw = clamp16(floor_shr(dh * longint'(cfg.gain_ang), 8));
                rotate_by_heading(vx, vy, lh);
                w.cmd = 1; w.status = pap_pkg::ST_ADJ;
            end
        end
        w.vx = vx[15:0]; w.vy = vy[15:0]; w.vyaw = vyaw[15:0];
        cmd_queue.push_back(w);
    endtask

    always @(posedge i_clk) begin
        t_cmd_word got, want;
        if (!i_rst_n) begin
            cfg <= '{pap_pkg::RST_XY_TOL, pap_pkg::RST_YAW_TOL, pap_pkg::RST_GAIN_L,
                     pap_pkg::RST_GAIN_A, pap_pkg::RST_TIMEOUT, pap_pkg::RST_DWELL};
            gx = 0; gy = 0; gh = 0; lx = 0; ly = 0; lh = 0;
            elapsed = 0; dwell = 0; mode = pap_pkg::MODE_IDLE;
            cmd_queue.delete();
            fails = 0;
            results = 0;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    pap_pkg::REG_XY_TOL:  cfg.xy_tol <= pwdata[14:0];
                    pap_pkg::REG_YAW_TOL: cfg.yaw_tol <= pwdata[14:0];
                    pap_pkg::REG_GAIN_L:  cfg.gain_lin <= pwdata[11:0];
                    pap_pkg::REG_GAIN_A:  cfg.gain_ang <= pwdata[11:0];
                    pap_pkg::REG_TIMEOUT: cfg.timeout_ticks <= pwdata[15:0];
                    pap_pkg::REG_DWELL:   cfg.dwell_ticks <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_command(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                got.vx     = m_tdata[15:0];
                got.vy     = m_tdata[31:16];
                got.vyaw   = m_tdata[47:32];
                got.cmd    = m_tuser[0];
                got.status = m_tuser[3:1];
                results++;
                if (cmd_queue.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("Unexpected word %h", got);
                end else begin
                    want = cmd_queue.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("Mismatch: expected vx %h vy %h yaw %h cmd %b st %0d,",
                                     want.vx, want.vy, want.vyaw, want.cmd, want.status);
                            $display("          got vx %h vy %h yaw %h cmd %b st %0d",
                                     got.vx, got.vy, got.vyaw, got.cmd, got.status);
                        end
                    end
                end
            end
        end
        o_pending = cmd_queue.size();
    end

    assign o_fail_count   = fails;
    assign o_result_count = results;
endmodule

FILE: bench/pose_align_p_controller_tb.sv
module pose_align_p_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending, result_count;
    int          cycles = 0;
    int          hold_off = 0;
    int          sent = 0;
    logic [15:0] gx, gy, gh;

    always #4 i_clk = ~i_clk;

    pose_align_p_controller dut (.*);

    pose_align_p_controller_chk u_chk (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The receiver stalls on its own pattern, with an occasional long hold-off.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end else if ($urandom_range(0, 199) == 0) begin
            hold_off <= 300;
            m_tready <= 0;
        end else begin
            m_tready <= (cycles % 64) < 40 ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic send_word(input logic [1:0] act, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] h);
        s_tvalid <= 1;
        s_tuser <= act;
        s_tdata <= {h, y, x};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
        if ($urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    task automatic set_config(input int sel);
        case (sel)
            0: begin
                write_reg(pap_pkg::REG_XY_TOL, 0); write_reg(pap_pkg::REG_YAW_TOL, 0);
                write_reg(pap_pkg::REG_GAIN_L, 4095); write_reg(pap_pkg::REG_GAIN_A, 4095);
                write_reg(pap_pkg::REG_TIMEOUT, 0); write_reg(pap_pkg::REG_DWELL, 0);
            end
            1: begin
                write_reg(pap_pkg::REG_XY_TOL, 32767); write_reg(pap_pkg::REG_YAW_TOL, 32767);
                write_reg(pap_pkg::REG_GAIN_L, 0); write_reg(pap_pkg::REG_GAIN_A, 0);
                write_reg(pap_pkg::REG_TIMEOUT, 65535); write_reg(pap_pkg::REG_DWELL, 65535);
            end
            2: begin
                write_reg(pap_pkg::REG_XY_TOL, 200); write_reg(pap_pkg::REG_YAW_TOL, 2000);
                write_reg(pap_pkg::REG_GAIN_L, 256); write_reg(pap_pkg::REG_GAIN_A, 300);
                write_reg(pap_pkg::REG_TIMEOUT, 40); write_reg(pap_pkg::REG_DWELL, 3);
            end
            default: begin
                write_reg(pap_pkg::REG_XY_TOL, $urandom_range(0, 2000));
                write_reg(pap_pkg::REG_YAW_TOL, $urandom_range(0, 5000));
                write_reg(pap_pkg::REG_GAIN_L, $urandom_range(0, 4095));
                write_reg(pap_pkg::REG_GAIN_A, $urandom_range(0, 4095));
                write_reg(pap_pkg::REG_TIMEOUT, $urandom_range(2, 60));
                write_reg(pap_pkg::REG_DWELL, $urandom_range(1, 6));
            end
        endcase
    endtask

    // A run: a start, then measurements near the goal, mixed with stray ticks.
    task automatic random_run();
        int len;
        logic [15:0] x, y, h;
        gx = 16'($urandom); gy = 16'($urandom); gh = 16'($urandom);
        send_word(pap_pkg::ACT_START, gx, gy, gh);
        len = $urandom_range(3, 20);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0: send_word(pap_pkg::ACT_FAIL, 16'($urandom), 16'($urandom), 16'($urandom));
                1: send_word(pap_pkg::ACT_NONE, 16'($urandom), 16'($urandom), 16'($urandom));
                2, 3: send_word(pap_pkg::ACT_MEAS, 16'($urandom), 16'($urandom),
                                16'($urandom));
                default: begin
                    x = gx + 16'($signed($urandom_range(0, 400)) - 200);
                    y = gy + 16'($signed($urandom_range(0, 400)) - 200);
                    h = gh + 16'($signed($urandom_range(0, 4000)) - 2000);
                    send_word(pap_pkg::ACT_MEAS, x, y, h);
                end
            endcase
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed part on reset settings.
        send_word(pap_pkg::ACT_MEAS, 16'h1234, 16'h5678, 16'h9abc);
        send_word(pap_pkg::ACT_NONE, 16'hffff, 16'hffff, 16'hffff);
        send_word(pap_pkg::ACT_START, 16'h7fff, 16'h8000, 16'hffff);
        send_word(pap_pkg::ACT_MEAS, 16'h8000, 16'h7fff, 16'h0000);
        send_word(pap_pkg::ACT_FAIL, 16'd0, 16'd0, 16'd0);
        send_word(pap_pkg::ACT_NONE, 16'd0, 16'd0, 16'd0);
        send_word(pap_pkg::ACT_MEAS, 16'h7fff, 16'h8000, 16'hffff);
        send_word(pap_pkg::ACT_START, 16'd0, 16'd0, 16'h4000);
        send_word(pap_pkg::ACT_MEAS, 16'd500, -16'sd500, 16'hc000);
        send_word(pap_pkg::ACT_MEAS, 16'd0, 16'd0, 16'h8000);
        send_word(pap_pkg::ACT_FAIL, 16'd0, 16'd0, 16'd0);
        send_word(pap_pkg::ACT_MEAS, 16'd0, 16'd0, 16'h4000);
        send_word(pap_pkg::ACT_FAIL, 16'd0, 16'd0, 16'd0);
        drain();
        set_config(0);
        send_word(pap_pkg::ACT_START, 16'd100, 16'd100, 16'd0);
        send_word(pap_pkg::ACT_MEAS, 16'd100, 16'd100, 16'd0);
        send_word(pap_pkg::ACT_START, 16'd100, 16'd100, 16'd0);
        send_word(pap_pkg::ACT_MEAS, 16'd0, 16'd0, 16'd100);
        send_word(pap_pkg::ACT_START, 16'd100, 16'd100, 16'd0);
        send_word(pap_pkg::ACT_FAIL, 16'd0, 16'd0, 16'd0);
        drain();
        set_config(1);
        send_word(pap_pkg::ACT_START, 16'h7fff, 16'h7fff, 16'h8000);
        send_word(pap_pkg::ACT_MEAS, 16'h8000, 16'h8000, 16'h0000);
        send_word(pap_pkg::ACT_FAIL, 16'd0, 16'd0, 16'd0);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            set_config(phase == 0 ? 2 : 3 + phase);
            for (int r = 0; r < 5; r++) random_run();
            drain();
        end

        drain();
        $display("Covered %0d input words and %0d result words over several settings,",
                 sent, result_count);
        $display("including starts, measurements, failed measurements, timeouts and dwells.");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

FILE: pose_align_p_controller.f
+incdir+design
design/pap_pkg.sv
design/pap_ctrl.sv
design/pap_dp.sv
design/pose_align_p_controller.sv
bench/pose_align_p_controller_chk.sv
bench/pose_align_p_controller_tb.sv
